[rtl/sample_frame_metadata_decoder_unit_defines.svh]
// assertion macros shared by the sample frame metadata decoder rtl
// expects clk and rst_n in the scope of each use
`ifndef SAMPLE_FRAME_METADATA_DECODER_UNIT_DEFINES_SVH
`define SAMPLE_FRAME_METADATA_DECODER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SFMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SFMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfmd_pkg.sv]
// types and constants of the sample frame metadata decoder
// no dependencies
`default_nettype none

package sfmd_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int DI_LINES     = 4;
  localparam int DI_SLOTS     = 4;
  localparam int MAX_RESULTS  = 4;

  localparam logic [6:0] CH_RESET = 7'd32;
  localparam logic [6:0] CH_MIN   = 7'd2;
  localparam logic [6:0] CH_MAX   = 7'(MAX_CHANNELS);
  localparam logic [7:0] ID_BASE  = 8'h20;
  localparam logic [3:0] FRM_LAST = 4'd4;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ID    = 2'd1,
    ERR_FRAME = 2'd2,
    ERR_SEQ   = 2'd3
  } err_t;

  typedef struct packed {
    logic [31:0]                 sample_number;
    logic [31:0]                 soft_word_one;
    logic [31:0]                 soft_word_two;
    logic [3:0]                  digital_inputs;
    err_t                        error_code;
    logic [DI_SLOTS-1:0][31:0]   edges;
    logic [47:0]                 samples_total;
    logic                        last;
  } rec_t;

  typedef struct packed {
    logic [2:0]                   cnt;
    rec_t [MAX_RESULTS-1:0]       rec;
  } load_t;

endpackage

`default_nettype wire

[rtl/sfmd_in_stage.sv]
// input register of the decoder, holds one stream word
// uses sfmd_pkg
`default_nettype none

module sfmd_in_stage
  import sfmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic        take,
  output logic             word_vld,
  output logic [31:0]      word
);

  logic        vld_r, vld_nxt;
  logic [31:0] word_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;
  assign word_vld = vld_r;
  assign word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= in_data_word;
    end
  end

endmodule

`default_nettype wire

[rtl/sfmd_decode.sv]
// frame state, id and subframe checks, record assembly for one word
// uses sfmd_pkg and the assertion macro header
`default_nettype none

`include "sample_frame_metadata_decoder_unit_defines.svh"

module sfmd_decode
  import sfmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [6:0]  cfg_channel_count,
  input  wire logic        word_vld,
  input  wire logic [31:0] word,
  input  wire logic        buf_free,
  output logic             take,
  output load_t            load
);

  logic [6:0]              ch_r;
  logic [6:0]              col_r, col_nxt;
  logic                    id_fault_r, id_fault_nxt;
  logic [2:0]              prev_r, prev_nxt;
  logic [2:0]              fill_r, fill_nxt;
  logic [31:0]             cnt_sh_r, cnt_sh_nxt;
  logic [31:0]             s1_sh_r, s1_sh_nxt;
  logic [31:0]             s2_sh_r, s2_sh_nxt;
  logic [3:0]              gdi_r [DI_SLOTS];
  logic [3:0]              pdi_r, pdi_nxt;
  logic                    pdv_r, pdv_nxt;
  logic [DI_SLOTS-1:0][31:0] edge_r, edge_nxt;
  logic [47:0]             smp_r, smp_nxt;
  logic                    halted_r, halted_nxt;

  logic [6:0]  n_eff, nm1;
  logic        is_trailer, id_bad, gdi_we;
  logic [7:0]  id;
  logic [3:0]  frm, di;
  err_t        err;
  logic [31:0] cnt_new, s1_new, s2_new;
  logic [47:0] smp_inc;

  assign n_eff = (ch_r < CH_MIN) ? CH_MIN : ((ch_r > CH_MAX) ? CH_MAX : ch_r);
  assign nm1   = n_eff - 7'd1;
  assign is_trailer = col_r >= n_eff;
  assign id    = word[7:0];
  assign frm   = word[3:0];
  assign di    = word[7:4];
  assign id_bad = ((col_r == 7'd0) && (id != ID_BASE)) ||
                  ((col_r == 7'd1) && (id != 8'(ID_BASE + 8'd1))) ||
                  ((col_r == nm1) && (id != 8'(ID_BASE + {1'b0, nm1})));
  assign cnt_new = {cnt_sh_r[23:0], word[31:24]};
  assign s1_new  = {s1_sh_r[23:0], word[23:16]};
  assign s2_new  = {s2_sh_r[23:0], word[15:8]};
  assign smp_inc = smp_r + 48'd1;

  assign take = word_vld && (halted_r || !is_trailer || buf_free);

  always_comb begin
    err = ERR_NONE;
    if (id_fault_r) begin
      err = ERR_ID;
    end else if ((frm < 4'd1) || (frm > FRM_LAST)) begin
      err = ERR_FRAME;
    end else if ((smp_r != 48'd0) && (frm != ({1'b0, prev_r} + 4'd1))) begin
      err = ERR_SEQ;
    end else if (fill_r >= 3'd4) begin
      err = ERR_SEQ;
    end
  end

  always_comb begin
    logic [3:0]               d;
    logic [3:0]               pd;
    logic                     pv;
    logic [3:0]               chg;
    logic [DI_SLOTS-1:0][31:0] acc;
    load       = '0;
    col_nxt    = col_r;
    id_fault_nxt = id_fault_r;
    prev_nxt   = prev_r;
    fill_nxt   = fill_r;
    cnt_sh_nxt = cnt_sh_r;
    s1_sh_nxt  = s1_sh_r;
    s2_sh_nxt  = s2_sh_r;
    pdi_nxt    = pdi_r;
    pdv_nxt    = pdv_r;
    edge_nxt   = edge_r;
    smp_nxt    = smp_r;
    halted_nxt = halted_r;
    gdi_we     = 1'b0;
    d          = '0;
    chg        = '0;
    pd         = pdi_r;
    pv         = pdv_r;
    acc        = edge_r;
    if (take && !halted_r) begin
      if (!is_trailer) begin
        col_nxt      = col_r + 7'd1;
        id_fault_nxt = id_fault_r || id_bad;
      end else begin
        col_nxt      = '0;
        id_fault_nxt = 1'b0;
        if (err != ERR_NONE) begin
          halted_nxt = 1'b1;
          load.cnt   = 3'd1;
          load.rec[0].error_code    = err;
          load.rec[0].edges         = edge_r;
          load.rec[0].samples_total = smp_r;
          load.rec[0].last          = 1'b1;
        end else begin
          smp_nxt    = smp_inc;
          gdi_we     = 1'b1;
          fill_nxt   = fill_r + 3'd1;
          cnt_sh_nxt = cnt_new;
          s1_sh_nxt  = s1_new;
          s2_sh_nxt  = s2_new;
          prev_nxt   = frm[2:0];
          if (frm == FRM_LAST) begin
            load.cnt = fill_r + 3'd1;
            for (int k = 0; k < MAX_RESULTS; k++) begin
              d = (3'(k) == fill_r) ? di : gdi_r[k];
              if (3'(k) <= fill_r) begin
                chg = pv ? (pd ^ d) : 4'd0;
                for (int l = 0; l < DI_SLOTS; l++) begin
                  if (l < DI_LINES) begin
                    acc[l] = acc[l] + {31'd0, chg[l]};
                  end
                end
                pd = d;
                pv = 1'b1;
                load.rec[k].sample_number  = cnt_new - {29'd0, 3'(fill_r - 3'(k))};
                load.rec[k].soft_word_one  = s1_new;
                load.rec[k].soft_word_two  = s2_new;
                load.rec[k].digital_inputs = d;
                load.rec[k].error_code     = ERR_NONE;
                load.rec[k].edges          = acc;
                load.rec[k].samples_total  = smp_inc;
                load.rec[k].last           = (3'(k) == fill_r);
              end
            end
            edge_nxt   = acc;
            pdi_nxt    = pd;
            pdv_nxt    = pv;
            fill_nxt   = '0;
            cnt_sh_nxt = '0;
            s1_sh_nxt  = '0;
            s2_sh_nxt  = '0;
            prev_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r       <= CH_RESET;
      col_r      <= '0;
      id_fault_r <= 1'b0;
      prev_r     <= '0;
      fill_r     <= '0;
      cnt_sh_r   <= '0;
      s1_sh_r    <= '0;
      s2_sh_r    <= '0;
      pdi_r      <= '0;
      pdv_r      <= 1'b0;
      edge_r     <= '0;
      smp_r      <= '0;
      halted_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ch_r <= cfg_channel_count;
      end
      col_r      <= col_nxt;
      id_fault_r <= id_fault_nxt;
      prev_r     <= prev_nxt;
      fill_r     <= fill_nxt;
      cnt_sh_r   <= cnt_sh_nxt;
      s1_sh_r    <= s1_sh_nxt;
      s2_sh_r    <= s2_sh_nxt;
      pdi_r      <= pdi_nxt;
      pdv_r      <= pdv_nxt;
      edge_r     <= edge_nxt;
      smp_r      <= smp_nxt;
      halted_r   <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gdi_we) begin
      gdi_r[fill_r[1:0]] <= di;
    end
  end

  `SFMD_ASSERT_IMP(a_halt_silent, halted_r, load.cnt == 3'd0, "records after halt")
  `SFMD_ASSERT_NXT(a_err_halts, (load.cnt != 3'd0) && (load.rec[0].error_code != ERR_NONE),
                   halted_r, "error record without halt")

endmodule

`default_nettype wire

[rtl/sfmd_burst_buf.sv]
// result register and burst buffer, drains up to four records one a cycle while out_ready is high
// uses sfmd_pkg and the assertion macro header
`default_nettype none

`include "sample_frame_metadata_decoder_unit_defines.svh"

module sfmd_burst_buf
  import sfmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire load_t load,
  output logic       buf_free,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rec_t       out_rec
);

  rec_t       slot_r [MAX_RESULTS];
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_fire, do_load;

  assign out_valid = cnt_r != 3'd0;
  assign out_fire  = out_valid && out_ready;
  assign buf_free  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign do_load   = load.cnt != 3'd0;
  assign out_rec   = slot_r[0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_load) begin
      cnt_nxt = load.cnt;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot_r[i] <= load.rec[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  `SFMD_ASSERT_IMP(a_load_free, do_load, buf_free, "burst loaded over pending records")
  `SFMD_ASSERT_NXT(a_load_shows, do_load, out_valid, "loaded burst not presented")
  `SFMD_ASSERT_IMP(a_tail_last, cnt_r == 3'd1, out_rec.last, "final record without last")

endmodule

`default_nettype wire

[rtl/sample_frame_metadata_decoder_unit.sv]
// Sample frame metadata decoder. Takes one 32-bit stream word per cycle while no trailer
// waits: channel_count data words, whose channel-id bytes in columns 0, 1 and last are
// checked, then a trailer word with subframe, DI bits and count/SEW bytes. The trailer of
// subframe 4 releases one record per buffered sample (one to four), presented one per
// cycle while out_ready is high from a four-slot output buffer; a word passes the input
// register to the decode stage, and its records are registered in the output buffer.
// Data words in the input register are always taken; only a trailer waits there while an
// earlier burst still drains. An error gives one error record and the block then
// swallows all words until reset. No clearing pass follows reset. cfg_channel_count is
// taken whenever cfg_valid is high and is used saturated to 2..64.
// uses sfmd_pkg, sfmd_in_stage, sfmd_decode, sfmd_burst_buf
`default_nettype none

module sample_frame_metadata_decoder_unit
  import sfmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_channel_count,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sample_number,
  output logic [31:0]      out_soft_word_one,
  output logic [31:0]      out_soft_word_two,
  output logic [3:0]       out_digital_inputs,
  output logic [1:0]       out_error_code,
  output logic [31:0]      out_edges_line0,
  output logic [31:0]      out_edges_line1,
  output logic [31:0]      out_edges_line2,
  output logic [31:0]      out_edges_line3,
  output logic [47:0]      out_samples_total,
  output logic             out_last
);

  logic        word_vld, take, buf_free;
  logic [31:0] word;
  load_t       load;
  rec_t        out_rec;

  assign cfg_ready = 1'b1;

  sfmd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .take         (take),
    .word_vld     (word_vld),
    .word         (word)
  );

  sfmd_decode u_dec (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_channel_count (cfg_channel_count),
    .word_vld          (word_vld),
    .word              (word),
    .buf_free          (buf_free),
    .take              (take),
    .load              (load)
  );

  sfmd_burst_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign out_sample_number  = out_rec.sample_number;
  assign out_soft_word_one  = out_rec.soft_word_one;
  assign out_soft_word_two  = out_rec.soft_word_two;
  assign out_digital_inputs = out_rec.digital_inputs;
  assign out_error_code     = out_rec.error_code;
  assign out_edges_line0    = out_rec.edges[0];
  assign out_edges_line1    = out_rec.edges[1];
  assign out_edges_line2    = out_rec.edges[2];
  assign out_edges_line3    = out_rec.edges[3];
  assign out_samples_total  = out_rec.samples_total;
  assign out_last           = out_rec.last;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for sample_frame_metadata_decoder_unit: sample streams of data
// columns and trailers go in, decoded records are checked against an in-bench predictor
// depends on sfmd_pkg and the decoder rtl
`timescale 1ns / 1ps

module testbench;
  import sfmd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_channel_count = CH_RESET;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sample_number;
  logic [31:0] out_soft_word_one;
  logic [31:0] out_soft_word_two;
  logic [3:0]  out_digital_inputs;
  logic [1:0]  out_error_code;
  logic [31:0] out_edges_line0;
  logic [31:0] out_edges_line1;
  logic [31:0] out_edges_line2;
  logic [31:0] out_edges_line3;
  logic [47:0] out_samples_total;
  logic        out_last;

  sample_frame_metadata_decoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_channel_count  (cfg_channel_count),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_word       (in_data_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_number  (out_sample_number),
    .out_soft_word_one  (out_soft_word_one),
    .out_soft_word_two  (out_soft_word_two),
    .out_digital_inputs (out_digital_inputs),
    .out_error_code     (out_error_code),
    .out_edges_line0    (out_edges_line0),
    .out_edges_line1    (out_edges_line1),
    .out_edges_line2    (out_edges_line2),
    .out_edges_line3    (out_edges_line3),
    .out_samples_total  (out_samples_total),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  logic [31:0] pending_words[$];
  rec_t        expected_records[$];
  int          fail_count = 0;
  int          records_predicted = 0;
  int          words_queued = 0;
  int          sender_idle_pct = 31;
  int          receiver_idle_pct = 48;

  // decoder predictor state
  logic [6:0]  chan_setting = CH_RESET;
  int          col_pos = 0;
  logic        id_bad = 1'b0;
  logic [2:0]  prior_frame = '0;
  logic [2:0]  group_size = '0;
  logic [31:0] count_acc = '0;
  logic [31:0] sew1_acc = '0;
  logic [31:0] sew2_acc = '0;
  logic [3:0]  group_di[4];
  logic [3:0]  seen_di = '0;
  logic        seen_di_ok = 1'b0;
  logic [31:0] edge_totals[4] = '{default: '0};
  logic [47:0] valid_samples = '0;
  logic        stopped = 1'b0;

  // stream generator position
  int          gen_n = 32;
  int          gen_col = 0;
  logic [3:0]  gen_frame = 4'd1;

  function automatic int eff_count(input logic [6:0] v);
    if (v < CH_MIN) return CH_MIN;
    if (v > CH_MAX) return CH_MAX;
    return v;
  endfunction

  function automatic rec_t make_rec(input logic [31:0] num, input logic [31:0] s1,
                                    input logic [31:0] s2, input logic [3:0] di,
                                    input err_t code, input logic fin);
    rec_t r;
    int   i;
    r.sample_number  = num;
    r.soft_word_one  = s1;
    r.soft_word_two  = s2;
    r.digital_inputs = di;
    r.error_code     = code;
    for (i = 0; i < DI_SLOTS; i++) r.edges[i] = edge_totals[i];
    r.samples_total  = valid_samples;
    r.last           = fin;
    return r;
  endfunction

  task automatic decode_word(input logic [31:0] w);
    int         n;
    int         cnt;
    int         k;
    int         line;
    logic [3:0] frm;
    logic [3:0] d;
    err_t       code;
    n = eff_count(chan_setting);
    code = ERR_NONE;
    if (stopped) return;
    if (col_pos < n) begin
      if ((col_pos == 0 && w[7:0] != ID_BASE) ||
          (col_pos == 1 && w[7:0] != ID_BASE + 8'd1) ||
          (col_pos == n - 1 && w[7:0] != 8'(ID_BASE + n - 1)))
        id_bad = 1'b1;
      col_pos++;
      return;
    end
    // trailer
    frm = w[3:0];
    col_pos = 0;
    if (id_bad) code = ERR_ID;
    else if (frm < 4'd1 || frm > FRM_LAST) code = ERR_FRAME;
    else if (valid_samples != 0 && int'(frm) != int'(prior_frame) + 1) code = ERR_SEQ;
    else if (group_size >= 3'd4) code = ERR_SEQ;
    id_bad = 1'b0;
    if (code != ERR_NONE) begin
      stopped = 1'b1;
      expected_records.push_back(make_rec('0, '0, '0, '0, code, 1'b1));
      records_predicted++;
      return;
    end
    valid_samples++;
    group_di[group_size[1:0]] = w[7:4];
    group_size++;
    count_acc = {count_acc[23:0], w[31:24]};
    sew1_acc = {sew1_acc[23:0], w[23:16]};
    sew2_acc = {sew2_acc[23:0], w[15:8]};
    prior_frame = frm[2:0];
    if (frm != FRM_LAST) return;
    cnt = group_size;
    for (k = 0; k < cnt; k++) begin
      d = group_di[k];
      if (seen_di_ok)
        for (line = 0; line < DI_LINES; line++)
          if (seen_di[line] != d[line]) edge_totals[line]++;
      seen_di = d;
      seen_di_ok = 1'b1;
      expected_records.push_back(make_rec(count_acc - 32'(cnt - 1 - k), sew1_acc, sew2_acc,
                                          d, ERR_NONE, k + 1 == cnt));
      records_predicted++;
    end
    group_size = '0;
    count_acc = '0;
    sew1_acc = '0;
    sew2_acc = '0;
    prior_frame = '0;
  endtask

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : word_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_word(in_data_word);
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : record_monitor
    rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          $error("record with none pending, sample_number %h", out_sample_number);
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("sample_number", want.sample_number, out_sample_number);
          check_field("soft_word_one", want.soft_word_one, out_soft_word_one);
          check_field("soft_word_two", want.soft_word_two, out_soft_word_two);
          check_field("digital_inputs", want.digital_inputs, out_digital_inputs);
          check_field("error_code", want.error_code, out_error_code);
          check_field("edges_line0", want.edges[0], out_edges_line0);
          check_field("edges_line1", want.edges[1], out_edges_line1);
          check_field("edges_line2", want.edges[2], out_edges_line2);
          check_field("edges_line3", want.edges[3], out_edges_line3);
          check_field("samples_total", want.samples_total, out_samples_total);
          check_field("last", want.last, out_last);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic queue_word(input logic [31:0] w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // data column at the current position, id byte corrupted when bad_col matches
  task automatic add_column(input int bad_col);
    logic [31:0] w;
    w = $urandom;
    if (gen_col == 0) w[7:0] = ID_BASE;
    if (gen_col == 1) w[7:0] = ID_BASE + 8'd1;
    if (gen_col == gen_n - 1) w[7:0] = 8'(ID_BASE + gen_n - 1);
    if (gen_col == bad_col) w[7:0] = w[7:0] ^ 8'(1 << $urandom_range(7));
    queue_word(w);
    gen_col++;
  endtask

  task automatic add_sample(input int bad_col, input logic [31:0] trailer);
    while (gen_col < gen_n) add_column(bad_col);
    queue_word(trailer);
    gen_col = 0;
    gen_frame = (trailer[3:0] == FRM_LAST) ? 4'd1 : trailer[3:0] + 4'd1;
  endtask

  function automatic logic [31:0] rand_trailer(input logic [3:0] frm);
    logic [31:0] w;
    w = $urandom;
    w[3:0] = frm;
    return w;
  endfunction

  // wait until every transaction is through and the pipeline has emptied
  task automatic settle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_records.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_channels(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_channel_count <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    chan_setting = v;
    gen_n = eff_count(v);
  endtask

  initial begin : stimulus
    logic [6:0] v;
    logic [3:0] f;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // short first group with wrapping sample numbers, then an all-ones group
    settle();
    set_channels(7'd0);
    add_sample(-1, 32'h0000_0003);
    add_sample(-1, 32'h0000_00f4);
    add_sample(-1, 32'hffff_ff51);
    add_sample(-1, 32'hffff_ffa2);
    add_sample(-1, 32'hffff_ff03);
    add_sample(-1, 32'hffff_fff4);
    // shrink the count mid-sample so the next word becomes the trailer
    settle();
    set_channels(7'd127);
    repeat (5) add_column(-1);
    settle();
    set_channels(7'd3);
    add_sample(-1, rand_trailer(gen_frame));

    while (words_queued < 230 || records_predicted < 48) begin
      if (words_queued >= 150) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end else if (words_queued >= 75) begin
        sender_idle_pct = 48;
        receiver_idle_pct = 31;
      end
      settle();
      case ($urandom_range(9))
        0: v = CH_MAX;
        1: v = 7'($urandom_range(65, 127));
        2: v = 7'($urandom_range(0, 1));
        3: v = 7'($urandom_range(7, 63));
        default: v = 7'($urandom_range(2, 6));
      endcase
      set_channels(v);
      repeat (gen_n <= 8 ? $urandom_range(6, 16) : $urandom_range(1, 3))
        add_sample(-1, rand_trailer(gen_frame));
      if ($urandom_range(9) < 4) repeat ($urandom_range(1, gen_n - 1)) add_column(-1);
    end

    // one fault to finish, then words that must be swallowed
    settle();
    if (gen_col != 0) add_sample(-1, rand_trailer(gen_frame));
    repeat ($urandom_range(0, 3)) add_sample(-1, rand_trailer(gen_frame));
    f = 4'($urandom_range(0, 11));
    if (f != 4'd0) f = f + 4'd4;
    case ($urandom_range(5))
      0: add_sample($urandom_range(0, 1), rand_trailer(gen_frame));
      1: add_sample(gen_n - 1, rand_trailer(gen_frame));
      2: add_sample(0, rand_trailer(f));
      3, 4: add_sample(-1, rand_trailer(f));
      default: add_sample(-1, rand_trailer(4'((gen_frame - 1 + $urandom_range(1, 3)) % 4 + 1)));
    endcase
    repeat (8) queue_word($urandom);
    settle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sfmd_pkg.sv
rtl/sfmd_in_stage.sv
rtl/sfmd_decode.sv
rtl/sfmd_burst_buf.sv
rtl/sample_frame_metadata_decoder_unit.sv
tb/testbench.sv
